// ===== rtl/descriptor_ring_tracker_top_macros.svh =====
// Assertion macros for the ring tracker top
`ifndef DESCRIPTOR_RING_TRACKER_TOP_MACROS_SVH
`define DESCRIPTOR_RING_TRACKER_TOP_MACROS_SVH

// Condition and consequence in the same cycle
`define DRT_ASSERT_IMPL(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error("ring tracker assertion failed");

// Consequence in the cycle after the condition
`define DRT_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("ring tracker assertion failed");

`endif

// ===== rtl/drt_pkg.sv =====
package drt_pkg;

  localparam int RING_SLOTS_DEF = 64;
  localparam int OP_W      = 3;
  localparam int SLOT_IN_W = 6;
  localparam int SIZE_W    = 16;
  localparam int TAG_W     = 16;
  localparam int LIMIT_W   = 11;
  localparam int LEN_W     = 11;
  localparam int STAT_W    = LEN_W + 1;

  localparam logic [LIMIT_W-1:0] FRAME_LIMIT_RST = 11'd1522;

  typedef enum logic [OP_W-1:0] {
    OP_ADD_TX  = 3'd0,
    OP_ADD_RX  = 3'd1,
    OP_DONE_TX = 3'd2,
    OP_DONE_RX = 3'd3,
    OP_REAP_TX = 3'd4,
    OP_REAP_RX = 3'd5,
    OP_RESET   = 3'd6
  } op_t;

  typedef enum logic [2:0] {
    K_ACCEPTED = 3'd0,
    K_NO_SPACE = 3'd1,
    K_BAD_SIZE = 3'd2,
    K_TX_DONE  = 3'd3,
    K_RX_DONE  = 3'd4,
    K_ACK      = 3'd5
  } kind_t;

  typedef enum logic {
    ST_IDLE,
    ST_REAP
  } state_t;

  typedef struct packed {
    op_t                  op;
    logic [SLOT_IN_W-1:0] slot;
    logic [SIZE_W-1:0]    size;
    logic [TAG_W-1:0]     tag;
    logic                 rx_error;
  } in_t;

  typedef struct packed {
    kind_t              kind;
    logic [TAG_W-1:0]   done_tag;
    logic [LEN_W-1:0]   done_length;
    logic               done_error;
    logic               last;
  } out_t;

  // Strobes from the control path to the descriptor store
  typedef struct packed {
    logic tag_we;
    logic stat_we;
    logic rd_en;
  } store_cmd_t;

endpackage

// ===== rtl/drt_store.sv =====
module drt_store #(
  parameter int RING_SLOTS = drt_pkg::RING_SLOTS_DEF
) (
  input  logic                                clk,
  input  drt_pkg::store_cmd_t                 cmd,
  input  logic                                wr_rx,
  input  logic [$clog2(RING_SLOTS)-1:0]       wr_slot,
  input  logic [drt_pkg::TAG_W-1:0]           tag_wdata,
  input  logic [drt_pkg::STAT_W-1:0]          stat_wdata,
  input  logic                                rd_rx,
  input  logic [$clog2(RING_SLOTS)-1:0]       rd_slot,
  output logic [drt_pkg::TAG_W-1:0]           tag_rdata,
  output logic [drt_pkg::STAT_W-1:0]          stat_rdata
);
  import drt_pkg::*;

  localparam int SLOT_W    = $clog2(RING_SLOTS);
  localparam int TAG_DEPTH = 2 ** (SLOT_W + 1);

  // Tags of both rings, receive ring in the upper half
  logic [TAG_W-1:0]  tag_mem [TAG_DEPTH];
  // Received length and error flag per receive slot
  logic [STAT_W-1:0] stat_mem [RING_SLOTS];
  logic [TAG_W-1:0]  tag_rd_r;
  logic [STAT_W-1:0] stat_rd_r;

  // Write port
  always_ff @(posedge clk) begin
    if (cmd.tag_we) begin
      tag_mem[{wr_rx, wr_slot}] <= tag_wdata;
    end
    if (cmd.stat_we) begin
      stat_mem[wr_slot] <= stat_wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      tag_rd_r  <= tag_mem[{rd_rx, rd_slot}];
      stat_rd_r <= stat_mem[rd_slot];
    end
  end

  assign tag_rdata  = tag_rd_r;
  assign stat_rdata = stat_rd_r;

endmodule

// ===== rtl/descriptor_ring_tracker_top.sv =====
// Descriptor ring tracker: keeps a transmit and a receive ring of buffer descriptors.
// Input channel: an item (op, slot, size, tag, rx_error in in_data) is taken at a rising
// edge where start is high and busy is low.
// Result channel: each result beat sits on out_data for exactly one cycle with
// out_valid high; the receiver cannot stall, so every beat is delivered as it appears.
// Configuration: cfg_we writes cfg_wdata into frame_limit at the next edge, no wait.
// Add, card-done, reset and unused ops: one beat, in the cycle after acceptance; busy
// stays low, so one such item can be taken in every cycle.
// Reap: busy is high in the reap state, where up to RING_SLOTS buffers are reaped. The
// walk visits one slot per cycle, set by the single read port of the tag memory; beats
// follow one per cycle, each registered from a reap-state step entered on acceptance.
// The final beat of every item carries last.
// Reset (rst_n low at a clock edge): both rings empty, all slots disarmed, frame_limit
// back to 1522, no beat pending. Armed bits are flip-flops, so no clearing pass runs;
// the tag and status memories are left as they are and are only read after an add
// has written them.
module descriptor_ring_tracker_top #(
  parameter int RING_SLOTS = drt_pkg::RING_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  drt_pkg::in_t                  in_data,
  output logic                          out_valid,
  output drt_pkg::out_t                 out_data,
  input  logic                          cfg_we,
  input  logic [drt_pkg::LIMIT_W-1:0]   cfg_wdata
);
  import drt_pkg::*;

`include "descriptor_ring_tracker_top_macros.svh"

  localparam int SLOT_W = $clog2(RING_SLOTS);
  localparam logic [SLOT_W-1:0]    LAST_SLOT = SLOT_W'(RING_SLOTS - 1);
  localparam logic [SLOT_IN_W:0]   SLOT_LIM  = (SLOT_IN_W + 1)'(RING_SLOTS);

  function automatic logic [SLOT_W-1:0] next_of(input logic [SLOT_W-1:0] s);
    return (s == LAST_SLOT) ? '0 : s + SLOT_W'(1);
  endfunction

  state_t                 state_r, state_nxt;
  logic [LIMIT_W-1:0]     limit_r;
  logic [RING_SLOTS-1:0]  tx_armed_r, tx_armed_nxt;
  logic [RING_SLOTS-1:0]  rx_armed_r, rx_armed_nxt;
  logic [SLOT_W-1:0]      tx_head_r, tx_head_nxt, tx_next_r, tx_next_nxt;
  logic [SLOT_W-1:0]      rx_head_r, rx_head_nxt, rx_next_r, rx_next_nxt;
  logic                   tx_hv_r, tx_hv_nxt, rx_hv_r, rx_hv_nxt;
  logic [SLOT_W-1:0]      cnt_r, cnt_nxt;
  logic                   reap_rx_r, reap_rx_nxt;
  logic                   out_valid_r, out_valid_nxt;
  kind_t                  out_kind_r, out_kind_nxt;
  logic                   out_last_r, out_last_nxt;
  logic                   out_reap_r, out_reap_nxt;
  logic                   out_rx_r, out_rx_nxt;

  store_cmd_t             store_cmd;
  logic                   wr_rx;
  logic [SLOT_W-1:0]      wr_slot;
  logic [STAT_W-1:0]      stat_wdata;
  logic [SLOT_W-1:0]      rd_slot;
  logic [TAG_W-1:0]       tag_rdata;
  logic [STAT_W-1:0]      stat_rdata;

  logic                   add_rx;
  logic [SLOT_W-1:0]      add_slot, add_head;
  logic                   add_hv, size_bad, slot_ok;
  logic [SLOT_W-1:0]      slot_idx;
  logic [SLOT_W-1:0]      cur_head, cur_next, new_head;
  logic                   cur_hv, new_hv, walk_stop;
  logic [RING_SLOTS-1:0]  cur_armed;

  // Hold frame limit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= FRAME_LIMIT_RST;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  // Control and ring state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tx_armed_r  <= '0;
      rx_armed_r  <= '0;
      tx_head_r   <= '0;
      tx_next_r   <= '0;
      tx_hv_r     <= 1'b0;
      rx_head_r   <= '0;
      rx_next_r   <= '0;
      rx_hv_r     <= 1'b0;
      cnt_r       <= '0;
      reap_rx_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tx_armed_r  <= tx_armed_nxt;
      rx_armed_r  <= rx_armed_nxt;
      tx_head_r   <= tx_head_nxt;
      tx_next_r   <= tx_next_nxt;
      tx_hv_r     <= tx_hv_nxt;
      rx_head_r   <= rx_head_nxt;
      rx_next_r   <= rx_next_nxt;
      rx_hv_r     <= rx_hv_nxt;
      cnt_r       <= cnt_nxt;
      reap_rx_r   <= reap_rx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result beat attributes
  always_ff @(posedge clk) begin
    out_kind_r <= out_kind_nxt;
    out_last_r <= out_last_nxt;
    out_reap_r <= out_reap_nxt;
    out_rx_r   <= out_rx_nxt;
  end

  // Decode of the current item and of the ring under walk
  always_comb begin
    add_rx    = (in_data.op == OP_ADD_RX);
    add_slot  = add_rx ? rx_next_r : tx_next_r;
    add_head  = add_rx ? rx_head_r : tx_head_r;
    add_hv    = add_rx ? rx_hv_r : tx_hv_r;
    size_bad  = add_rx ? (in_data.size < SIZE_W'(limit_r))
                       : (in_data.size > SIZE_W'(limit_r));
    slot_ok   = ({1'b0, in_data.slot} < SLOT_LIM);
    slot_idx  = in_data.slot[SLOT_W-1:0];
    cur_head  = reap_rx_r ? rx_head_r : tx_head_r;
    cur_next  = reap_rx_r ? rx_next_r : tx_next_r;
    cur_hv    = reap_rx_r ? rx_hv_r : tx_hv_r;
    cur_armed = reap_rx_r ? rx_armed_r : tx_armed_r;
    new_head  = next_of(cur_head);
    new_hv    = (new_head != cur_next);
    walk_stop = !new_hv || cur_armed[new_head] || (cnt_r == LAST_SLOT);
  end

  // Next state, store strobes and result beat
  always_comb begin
    state_nxt     = state_r;
    tx_armed_nxt  = tx_armed_r;
    rx_armed_nxt  = rx_armed_r;
    tx_head_nxt   = tx_head_r;
    tx_next_nxt   = tx_next_r;
    tx_hv_nxt     = tx_hv_r;
    rx_head_nxt   = rx_head_r;
    rx_next_nxt   = rx_next_r;
    rx_hv_nxt     = rx_hv_r;
    cnt_nxt       = cnt_r;
    reap_rx_nxt   = reap_rx_r;
    out_valid_nxt = 1'b0;
    out_kind_nxt  = K_ACK;
    out_last_nxt  = 1'b1;
    out_reap_nxt  = 1'b0;
    out_rx_nxt    = 1'b0;
    store_cmd     = '0;
    wr_rx         = add_rx;
    wr_slot       = add_slot;
    stat_wdata    = '0;
    rd_slot       = cur_head;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          out_valid_nxt = 1'b1;
          case (in_data.op)
            OP_ADD_TX, OP_ADD_RX: begin
              if (add_hv && (add_head == add_slot)) begin
                out_kind_nxt = K_NO_SPACE;
              end else if (size_bad) begin
                out_kind_nxt = K_BAD_SIZE;
              end else begin
                // Arm the slot, store the tag, clear a fresh receive status
                out_kind_nxt      = K_ACCEPTED;
                store_cmd.tag_we  = 1'b1;
                store_cmd.stat_we = add_rx;
                if (add_rx) begin
                  rx_armed_nxt[add_slot] = 1'b1;
                  rx_next_nxt = next_of(add_slot);
                  if (!rx_hv_r) begin
                    rx_head_nxt = add_slot;
                    rx_hv_nxt   = 1'b1;
                  end
                end else begin
                  tx_armed_nxt[add_slot] = 1'b1;
                  tx_next_nxt = next_of(add_slot);
                  if (!tx_hv_r) begin
                    tx_head_nxt = add_slot;
                    tx_hv_nxt   = 1'b1;
                  end
                end
              end
            end
            OP_DONE_TX: begin
              if (slot_ok) begin
                tx_armed_nxt[slot_idx] = 1'b0;
              end
            end
            OP_DONE_RX: begin
              // Disarm and record length and error flag
              if (slot_ok) begin
                rx_armed_nxt[slot_idx] = 1'b0;
                store_cmd.stat_we      = 1'b1;
                wr_slot                = slot_idx;
                stat_wdata             = {in_data.size[LEN_W-1:0], in_data.rx_error};
              end
            end
            OP_REAP_TX, OP_REAP_RX: begin
              out_valid_nxt = 1'b0;
              state_nxt     = ST_REAP;
              reap_rx_nxt   = (in_data.op == OP_REAP_RX);
              cnt_nxt       = '0;
            end
            OP_RESET: begin
              tx_armed_nxt = '0;
              rx_armed_nxt = '0;
              tx_head_nxt  = '0;
              tx_next_nxt  = '0;
              tx_hv_nxt    = 1'b0;
              rx_head_nxt  = '0;
              rx_next_nxt  = '0;
              rx_hv_nxt    = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_REAP: begin
        out_valid_nxt = 1'b1;
        if (!cur_hv || cur_armed[cur_head]) begin
          // Nothing finished at the head: answer with a plain ack
          state_nxt = ST_IDLE;
        end else begin
          // Read the head slot and advance past it
          store_cmd.rd_en = 1'b1;
          out_kind_nxt    = reap_rx_r ? K_RX_DONE : K_TX_DONE;
          out_last_nxt    = walk_stop;
          out_reap_nxt    = 1'b1;
          out_rx_nxt      = reap_rx_r;
          cnt_nxt         = cnt_r + SLOT_W'(1);
          if (reap_rx_r) begin
            rx_head_nxt = new_head;
            rx_hv_nxt   = new_hv;
          end else begin
            tx_head_nxt = new_head;
            tx_hv_nxt   = new_hv;
          end
          if (walk_stop) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  drt_store #(
    .RING_SLOTS (RING_SLOTS)
  ) u_store (
    .clk        (clk),
    .cmd        (store_cmd),
    .wr_rx      (wr_rx),
    .wr_slot    (wr_slot),
    .tag_wdata  (in_data.tag),
    .stat_wdata (stat_wdata),
    .rd_rx      (reap_rx_r),
    .rd_slot    (rd_slot),
    .tag_rdata  (tag_rdata),
    .stat_rdata (stat_rdata)
  );

  // Drive the result beat
  assign busy      = (state_r == ST_REAP);
  assign out_valid = out_valid_r;
  always_comb begin
    out_data.kind        = out_kind_r;
    out_data.done_tag    = out_reap_r ? tag_rdata : '0;
    out_data.done_length = (out_reap_r && out_rx_r) ? stat_rdata[STAT_W-1:1] : '0;
    out_data.done_error  = out_reap_r && out_rx_r && stat_rdata[0];
    out_data.last        = out_last_r;
  end

  // The stores are never written while a walk reads them
  `DRT_ASSERT_IMPL(a_reap_no_write, clk, rst_n, state_r == ST_REAP, !store_cmd.tag_we && !store_cmd.stat_we)
  // Past the first step a walk always still has a head
  `DRT_ASSERT_IMPL(a_walk_has_head, clk, rst_n, (state_r == ST_REAP) && (cnt_r != '0), reap_rx_r ? rx_hv_r : tx_hv_r)
  // Items other than reaps answer with one final beat in the next cycle
  `DRT_ASSERT_NEXT(a_single_answer, clk, rst_n, start && !busy && (in_data.op != OP_REAP_TX) && (in_data.op != OP_REAP_RX), out_valid && out_data.last)

endmodule

// ===== verif/descriptor_ring_tracker_checker.sv =====
module descriptor_ring_tracker_checker #(
  parameter int RING_SLOTS = drt_pkg::RING_SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        busy,
  input  drt_pkg::in_t                in_data,
  input  logic                        out_valid,
  input  drt_pkg::out_t               out_data,
  input  logic                        cfg_we,
  input  logic [drt_pkg::LIMIT_W-1:0] cfg_wdata,
  output int                          beats_owed,
  output int                          fault_count
);
  import drt_pkg::*;

  // Print only the first few faults; the count keeps going
  localparam int MAX_SHOWN = 40;

  logic [LIMIT_W-1:0] limit_q;
  logic               tx_arm [RING_SLOTS];
  logic [TAG_W-1:0]   tx_tag [RING_SLOTS];
  logic               rx_arm [RING_SLOTS];
  logic [TAG_W-1:0]   rx_tag [RING_SLOTS];
  logic [LEN_W-1:0]   rx_len [RING_SLOTS];
  logic               rx_err [RING_SLOTS];
  int                 tx_head, tx_next, rx_head, rx_next;
  logic               tx_live, rx_live;

  // Beats still to come, oldest first
  out_t ring_answers [$];

  function automatic out_t make_beat(kind_t k, logic [TAG_W-1:0] t, logic [LEN_W-1:0] l,
                                     logic e, logic fin);
    out_t b;
    b.kind        = k;
    b.done_tag    = t;
    b.done_length = l;
    b.done_error  = e;
    b.last        = fin;
    return b;
  endfunction

  function automatic logic armed_at(logic rx, int s);
    return rx ? rx_arm[s] : tx_arm[s];
  endfunction

  // Empty both rings and zero every store
  task automatic clear_rings();
    for (int s = 0; s < RING_SLOTS; s++) begin
      tx_arm[s] = 1'b0;
      tx_tag[s] = '0;
      rx_arm[s] = 1'b0;
      rx_tag[s] = '0;
      rx_len[s] = '0;
      rx_err[s] = 1'b0;
    end
    tx_head = 0;
    tx_next = 0;
    tx_live = 1'b0;
    rx_head = 0;
    rx_next = 0;
    rx_live = 1'b0;
  endtask

  // Arm the next free slot unless the ring is full or the size is out of bounds
  task automatic add_desc(logic rx, in_t it);
    int   s;
    logic full;
    logic bad;
    s    = rx ? rx_next : tx_next;
    full = rx ? (rx_live && rx_head == s) : (tx_live && tx_head == s);
    bad  = rx ? (int'(it.size) < int'(limit_q)) : (int'(it.size) > int'(limit_q));
    if (full) begin
      ring_answers.push_back(make_beat(K_NO_SPACE, '0, '0, 1'b0, 1'b1));
    end else if (bad) begin
      ring_answers.push_back(make_beat(K_BAD_SIZE, '0, '0, 1'b0, 1'b1));
    end else begin
      if (rx) begin
        rx_arm[s] = 1'b1;
        rx_tag[s] = it.tag;
        rx_len[s] = '0;
        rx_err[s] = 1'b0;
        rx_next   = (s + 1) % RING_SLOTS;
        if (!rx_live) begin
          rx_head = s;
          rx_live = 1'b1;
        end
      end else begin
        tx_arm[s] = 1'b1;
        tx_tag[s] = it.tag;
        tx_next   = (s + 1) % RING_SLOTS;
        if (!tx_live) begin
          tx_head = s;
          tx_live = 1'b1;
        end
      end
      ring_answers.push_back(make_beat(K_ACCEPTED, '0, '0, 1'b0, 1'b1));
    end
  endtask

  // Walk from the head over disarmed slots, one beat per finished buffer
  task automatic reap_ring(logic rx);
    int   h;
    int   stop_at;
    int   n;
    logic live;
    out_t b;
    h       = rx ? rx_head : tx_head;
    live    = rx ? rx_live : tx_live;
    stop_at = rx ? rx_next : tx_next;
    n       = 0;
    while (n < RING_SLOTS && live && !armed_at(rx, h)) begin
      if (rx) begin
        b = make_beat(K_RX_DONE, rx_tag[h], rx_len[h], rx_err[h], 1'b0);
      end else begin
        b = make_beat(K_TX_DONE, tx_tag[h], '0, 1'b0, 1'b0);
      end
      n++;
      h = (h + 1) % RING_SLOTS;
      if (h == stop_at) live = 1'b0;
      // The walk ends here if the bound, the free slot or an armed slot stops it
      b.last = (n == RING_SLOTS) || !live || armed_at(rx, h);
      ring_answers.push_back(b);
    end
    if (n == 0) ring_answers.push_back(make_beat(K_ACK, '0, '0, 1'b0, 1'b1));
    if (rx) begin
      rx_head = h;
      rx_live = live;
    end else begin
      tx_head = h;
      tx_live = live;
    end
  endtask

  task automatic apply_ring_op(in_t it);
    case (it.op)
      OP_ADD_TX: add_desc(1'b0, it);
      OP_ADD_RX: add_desc(1'b1, it);
      OP_REAP_TX: reap_ring(1'b0);
      OP_REAP_RX: reap_ring(1'b1);
      OP_DONE_TX: begin
        if (int'(it.slot) < RING_SLOTS) tx_arm[it.slot] = 1'b0;
        ring_answers.push_back(make_beat(K_ACK, '0, '0, 1'b0, 1'b1));
      end
      OP_DONE_RX: begin
        if (int'(it.slot) < RING_SLOTS) begin
          rx_arm[it.slot] = 1'b0;
          rx_len[it.slot] = it.size[LEN_W-1:0];
          rx_err[it.slot] = it.rx_error;
        end
        ring_answers.push_back(make_beat(K_ACK, '0, '0, 1'b0, 1'b1));
      end
      OP_RESET: begin
        clear_rings();
        ring_answers.push_back(make_beat(K_ACK, '0, '0, 1'b0, 1'b1));
      end
      default: ring_answers.push_back(make_beat(K_ACK, '0, '0, 1'b0, 1'b1));
    endcase
  endtask

  task automatic report_fault(string msg);
    if (fault_count < MAX_SHOWN) $display("%0t ring tracker: %s", $time, msg);
    fault_count++;
  endtask

  // Match a result beat against the oldest one owed
  task automatic check_beat(out_t got);
    out_t want;
    if (ring_answers.size() == 0) begin
      report_fault($sformatf("beat with nothing owed: kind=%0d tag=%h len=%0d err=%b last=%b",
                             got.kind, got.done_tag, got.done_length, got.done_error,
                             got.last));
    end else begin
      want = ring_answers.pop_front();
      if (got.kind !== want.kind || got.done_tag !== want.done_tag ||
          got.done_length !== want.done_length || got.done_error !== want.done_error ||
          got.last !== want.last) begin
        report_fault($sformatf("got kind=%0d tag=%h len=%0d err=%b last=%b, want kind=%0d tag=%h len=%0d err=%b last=%b",
                               got.kind, got.done_tag, got.done_length, got.done_error,
                               got.last, want.kind, want.done_tag, want.done_length,
                               want.done_error, want.last));
      end
    end
  endtask

  // Check beats first: a beat never belongs to the item taken at the same edge
  always @(posedge clk) begin
    if (!rst_n) begin
      limit_q = FRAME_LIMIT_RST;
      clear_rings();
      ring_answers.delete();
    end else begin
      if (out_valid) check_beat(out_data);
      if (cfg_we) limit_q = cfg_wdata;
      if (start && !busy) apply_ring_op(in_data);
    end
    beats_owed <= ring_answers.size();
  end

endmodule

// ===== verif/descriptor_ring_tracker_top_tb.sv =====
module descriptor_ring_tracker_top_tb;
  import drt_pkg::*;

  localparam int  RING        = RING_SLOTS_DEF;
  localparam int  CYCLE_LIMIT = 400000;
  localparam op_t OP_SPARE    = op_t'(3'd7);

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               start     = 1'b0;
  in_t                in_data   = '0;
  logic               cfg_we    = 1'b0;
  logic [LIMIT_W-1:0] cfg_wdata = FRAME_LIMIT_RST;
  logic               busy;
  logic               out_valid;
  out_t               out_data;
  int                 beats_owed;
  int                 fault_count;

  int cycles     = 0;
  int sent       = 0;
  int limit_now  = int'(FRAME_LIMIT_RST);
  bit idle_on    = 1'b1;
  bit quiet_tail = 1'b0;
  // Where the next add to each ring should land, as far as the stimulus knows
  int fill_at [2] = '{0, 0};

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  descriptor_ring_tracker_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  descriptor_ring_tracker_checker #(.RING_SLOTS(RING)) ring_watch (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .beats_owed  (beats_owed),
    .fault_count (fault_count)
  );

  // Stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Present one item, after an optional idle burst, and hold it until taken
  task automatic issue(op_t op, logic [5:0] slot, logic [15:0] size, logic [15:0] tag,
                       logic err);
    int  gap;
    in_t it;
    gap = 0;
    if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 11);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    it.op       = op;
    it.slot     = slot;
    it.size     = size;
    it.tag      = tag;
    it.rx_error = err;
    start   <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy);
    sent++;
    if (op == OP_RESET) begin
      fill_at[0] = 0;
      fill_at[1] = 0;
    end
  endtask

  // Add a buffer whose size fits the current limit, or deliberately does not
  task automatic post_buffer(logic rx, logic fits, logic [15:0] tag);
    logic [15:0] sz;
    if (rx) begin
      sz = fits ? 16'($urandom_range(limit_now, 65535))
                : 16'($urandom_range(0, limit_now - 1));
    end else begin
      sz = fits ? 16'($urandom_range(0, limit_now))
                : 16'($urandom_range(limit_now + 1, 65535));
    end
    issue(rx ? OP_ADD_RX : OP_ADD_TX, 6'($urandom), sz, tag, 1'($urandom));
    if (fits) fill_at[rx] = (fill_at[rx] + 1) % RING;
  endtask

  task automatic mark_done(logic rx, int s);
    issue(rx ? OP_DONE_RX : OP_DONE_TX, 6'(s), 16'($urandom), 16'($urandom),
          1'($urandom));
  endtask

  task automatic reap(logic rx);
    issue(rx ? OP_REAP_RX : OP_REAP_TX, 6'($urandom), 16'($urandom), 16'($urandom),
          1'($urandom));
  endtask

  // Finish the given slots in random order, then reap
  task automatic finish_slots(logic rx, int slots [$], bit may_skip);
    int pick;
    while (slots.size() != 0) begin
      pick = $urandom_range(0, slots.size() - 1);
      if (!may_skip || $urandom_range(0, 9) != 0) mark_done(rx, slots[pick]);
      slots.delete(pick);
      if (may_skip && $urandom_range(0, 5) == 0) reap(rx);
    end
    reap(rx);
  endtask

  // A short run of adds, finished out of order, with the odd skip and early reap
  task automatic ring_batch(logic rx);
    int n;
    int slots [$];
    n = $urandom_range(1, 12);
    repeat (n) begin
      if ($urandom_range(0, 9) == 0) begin
        post_buffer(rx, 1'b0, 16'($urandom));
      end else begin
        slots.push_back(fill_at[rx]);
        post_buffer(rx, 1'b1, 16'($urandom));
      end
    end
    finish_slots(rx, slots, 1'b1);
  endtask

  // Fill a ring from empty, push past full, then finish and reap every slot
  task automatic ring_fill(logic rx);
    int slots [$];
    issue(OP_RESET, 6'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
    for (int s = 0; s < RING; s++) begin
      slots.push_back(s);
      post_buffer(rx, 1'b1, 16'($urandom));
    end
    issue(rx ? OP_ADD_RX : OP_ADD_TX, 6'($urandom), 16'($urandom), 16'($urandom),
          1'($urandom));
    issue(rx ? OP_ADD_RX : OP_ADD_TX, 6'($urandom), 16'($urandom), 16'($urandom),
          1'($urandom));
    finish_slots(rx, slots, 1'b0);
    reap(!rx);
  endtask

  task automatic stray_items();
    repeat ($urandom_range(1, 4)) begin
      issue(op_t'($urandom_range(0, 7)), 6'($urandom), 16'($urandom), 16'($urandom),
            1'($urandom));
    end
  endtask

  task automatic random_step();
    if (!quiet_tail) idle_on = ($urandom_range(0, 3) != 0);
    if ($urandom_range(0, 9) < 7) ring_batch(1'($urandom_range(0, 1)));
    else stray_items();
  endtask

  // Drop start and wait until every owed beat has arrived
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (beats_owed != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_limit(int v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= LIMIT_W'(v);
    limit_now = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed items at the reset limit
    issue(OP_REAP_TX, 6'h00, 16'h0000, 16'h0000, 1'b0);
    issue(OP_REAP_RX, 6'h3f, 16'hffff, 16'hffff, 1'b1);
    issue(OP_DONE_TX, 6'h3f, 16'h0000, 16'h0000, 1'b0);
    issue(OP_DONE_RX, 6'h00, 16'hffff, 16'hffff, 1'b1);
    issue(OP_SPARE, 6'h3f, 16'hffff, 16'hffff, 1'b1);
    issue(OP_ADD_TX, 6'h00, 16'd0, 16'h0000, 1'b0);
    issue(OP_ADD_TX, 6'h3f, 16'd1522, 16'hffff, 1'b1);
    issue(OP_ADD_TX, 6'h00, 16'd1523, 16'h1234, 1'b0);
    issue(OP_ADD_TX, 6'h00, 16'hffff, 16'h4321, 1'b0);
    issue(OP_ADD_RX, 6'h00, 16'd1521, 16'h1111, 1'b0);
    issue(OP_ADD_RX, 6'h00, 16'd1522, 16'h5a5a, 1'b0);
    issue(OP_ADD_RX, 6'h00, 16'hffff, 16'ha5a5, 1'b1);
    issue(OP_ADD_RX, 6'h00, 16'd0, 16'h2222, 1'b0);
    issue(OP_DONE_TX, 6'h01, 16'h0000, 16'h0000, 1'b0);
    issue(OP_REAP_TX, 6'h00, 16'h0000, 16'h0000, 1'b0);
    issue(OP_DONE_TX, 6'h00, 16'h0000, 16'h0000, 1'b0);
    issue(OP_REAP_TX, 6'h00, 16'h0000, 16'h0000, 1'b0);
    issue(OP_DONE_RX, 6'h00, 16'hffff, 16'h0000, 1'b1);
    issue(OP_DONE_RX, 6'h01, 16'h0000, 16'h0000, 1'b0);
    issue(OP_REAP_RX, 6'h00, 16'h0000, 16'h0000, 1'b0);
    issue(OP_ADD_TX, 6'h00, 16'd100, 16'hbeef, 1'b0);
    issue(OP_ADD_RX, 6'h00, 16'd2000, 16'hcafe, 1'b0);
    issue(OP_RESET, 6'h00, 16'h0000, 16'h0000, 1'b0);
    issue(OP_REAP_TX, 6'h00, 16'h0000, 16'h0000, 1'b0);
    issue(OP_REAP_RX, 6'h00, 16'h0000, 16'h0000, 1'b0);

    // Largest limit, with one full ring walked end to end
    write_limit(2047);
    ring_fill(1'($urandom_range(0, 1)));
    while (sent < 175) random_step();

    // Smallest limit
    write_limit(64);
    while (sent < 215) random_step();

    // Some limit in between, sender never idles
    write_limit($urandom_range(65, 2046));
    quiet_tail = 1'b1;
    idle_on    = 1'b0;
    while (sent < 255) random_step();

    drain();
    if (fault_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
